@@ src/pvc_pkg.sv @@
// shared types and constants of the prefix varint codec
`timescale 1ns / 1ps

package pvc_pkg;

    // most bytes one encoding can take: header plus eight payload bytes
    localparam int BYTES_MAX = 9;

    // register indexes of the configuration port
    localparam logic CFG_DIRECTION   = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // header byte ranges
    localparam logic [7:0] HDR_ONE_MAX   = 8'd240;
    localparam logic [7:0] HDR_TWO_BASE  = 8'd241;
    localparam logic [7:0] HDR_TWO_MAX   = 8'd248;
    localparam logic [7:0] HDR_THREE     = 8'd249;
    localparam logic [7:0] HDR_WIDE_BASE = 8'd247;

    // value range limits
    localparam logic [63:0] VAL_ONE_MAX   = 64'd240;
    localparam logic [63:0] VAL_TWO_MAX   = 64'd2287;
    localparam logic [63:0] VAL_THREE_MAX = 64'd67823;
    localparam logic [11:0] VAL_TWO_BASE  = 12'd240;
    localparam logic [16:0] VAL_THREE_BASE = 17'd2288;

    // one unit of work handed from front to back
    typedef struct packed {
        logic                       is_decode;
        logic [3:0]                 count;
        logic [BYTES_MAX*8-1:0]     bytes;
        logic [63:0]                value;
    } job_t;

endpackage

@@ src/pvc_front.sv @@
// front part: configuration, input classification, encode framing, decode gathering
`timescale 1ns / 1ps

module pvc_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic          cfg_data,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic [71:0]   in_data,
    output logic          push,
    output pvc_pkg::job_t push_job
);

    logic        direction_reg;
    logic        signed_mode_reg;
    logic [3:0]  bytes_left_reg;
    logic [3:0]  bytes_left_next;
    logic [7:0]  header_seen_reg;
    logic [7:0]  header_seen_next;
    logic [3:0]  byte_position_reg;
    logic [3:0]  byte_position_next;
    logic [63:0] partial_value_reg;
    logic [63:0] partial_value_next;

    logic        accept;
    logic [63:0] value_in;
    logic [7:0]  byte_in;

    logic [63:0] enc_u;
    logic [11:0] enc_d2;
    logic [16:0] enc_d3;
    logic [3:0]  wide_len;
    pvc_pkg::job_t enc_job;

    logic        dec_done;
    logic [63:0] merged;
    logic [63:0] dec_raw;
    logic [7:0]  hdr_off;
    logic [11:0] two_sum;
    logic [16:0] three_sum;
    logic [63:0] dec_value;
    pvc_pkg::job_t dec_job;

    assign accept   = in_valid & in_ready;
    assign value_in = in_data[63:0];
    assign byte_in  = in_data[71:64];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= pvc_pkg::DIR_ENCODE;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pvc_pkg::CFG_DIRECTION:   direction_reg   <= cfg_data;
                pvc_pkg::CFG_SIGNED_MODE: signed_mode_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // encode: zigzag in signed mode, then pick the header and lay out the bytes
    always_comb
    begin
        enc_u = signed_mode_reg ? ({value_in[62:0], 1'b0} ^ {64{value_in[63]}}) : value_in;

        if (enc_u[63:56] != 8'd0)
            wide_len = 4'd8;
        else if (enc_u[55:48] != 8'd0)
            wide_len = 4'd7;
        else if (enc_u[47:40] != 8'd0)
            wide_len = 4'd6;
        else if (enc_u[39:32] != 8'd0)
            wide_len = 4'd5;
        else if (enc_u[31:24] != 8'd0)
            wide_len = 4'd4;
        else
            wide_len = 4'd3;

        enc_d2 = enc_u[11:0] - pvc_pkg::VAL_TWO_BASE;
        enc_d3 = enc_u[16:0] - pvc_pkg::VAL_THREE_BASE;

        enc_job           = '0;
        enc_job.is_decode = 1'b0;
        if (enc_u <= pvc_pkg::VAL_ONE_MAX)
        begin
            enc_job.count       = 4'd1;
            enc_job.bytes[7:0]  = enc_u[7:0];
        end
        else if (enc_u <= pvc_pkg::VAL_TWO_MAX)
        begin
            enc_job.count       = 4'd2;
            enc_job.bytes[7:0]  = {4'd0, enc_d2[11:8]} + pvc_pkg::HDR_TWO_BASE;
            enc_job.bytes[15:8] = enc_d2[7:0];
        end
        else if (enc_u <= pvc_pkg::VAL_THREE_MAX)
        begin
            enc_job.count        = 4'd3;
            enc_job.bytes[7:0]   = pvc_pkg::HDR_THREE;
            enc_job.bytes[15:8]  = enc_d3[15:8];
            enc_job.bytes[23:16] = enc_d3[7:0];
        end
        else
        begin
            // little-endian payload, only the first wide_len bytes go out
            enc_job.count       = wide_len + 4'd1;
            enc_job.bytes[7:0]  = pvc_pkg::HDR_WIDE_BASE + {4'd0, wide_len};
            enc_job.bytes[71:8] = enc_u;
        end
    end

    // decode: header sets the byte count, payload bytes gather into partial value
    always_comb
    begin
        bytes_left_next    = bytes_left_reg;
        header_seen_next   = header_seen_reg;
        byte_position_next = byte_position_reg;
        partial_value_next = partial_value_reg;
        dec_done           = 1'b0;
        dec_raw            = '0;

        if (header_seen_reg == pvc_pkg::HDR_THREE)
            merged = {partial_value_reg[55:0], byte_in};
        else
            merged = partial_value_reg
                   | ({56'd0, byte_in} << {byte_position_reg[2:0], 3'b000});

        hdr_off   = header_seen_reg - pvc_pkg::HDR_TWO_BASE;
        two_sum   = pvc_pkg::VAL_TWO_BASE + {1'b0, hdr_off[2:0], merged[7:0]};
        three_sum = pvc_pkg::VAL_THREE_BASE + {1'b0, merged[15:0]};

        if (bytes_left_reg == 4'd0)
        begin
            if (byte_in <= pvc_pkg::HDR_ONE_MAX)
            begin
                dec_done = 1'b1;
                dec_raw  = {56'd0, byte_in};
            end
            else
            begin
                header_seen_next   = byte_in;
                byte_position_next = 4'd0;
                partial_value_next = '0;
                if (byte_in <= pvc_pkg::HDR_TWO_MAX)
                    bytes_left_next = 4'd1;
                else if (byte_in == pvc_pkg::HDR_THREE)
                    bytes_left_next = 4'd2;
                else
                    bytes_left_next = 4'(byte_in - pvc_pkg::HDR_WIDE_BASE);
            end
        end
        else
        begin
            bytes_left_next    = bytes_left_reg - 4'd1;
            byte_position_next = byte_position_reg + 4'd1;
            partial_value_next = merged;
            if (bytes_left_reg == 4'd1)
            begin
                dec_done = 1'b1;
                if (header_seen_reg <= pvc_pkg::HDR_TWO_MAX)
                    dec_raw = {52'd0, two_sum};
                else if (header_seen_reg == pvc_pkg::HDR_THREE)
                    dec_raw = {47'd0, three_sum};
                else
                    dec_raw = merged;
                header_seen_next   = 8'd0;
                byte_position_next = 4'd0;
                partial_value_next = '0;
            end
        end

        dec_value = signed_mode_reg ? ({1'b0, dec_raw[63:1]} ^ {64{dec_raw[0]}}) : dec_raw;

        dec_job           = '0;
        dec_job.is_decode = 1'b1;
        dec_job.count     = 4'd1;
        dec_job.value     = dec_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= 4'd0;
            header_seen_reg   <= 8'd0;
            byte_position_reg <= 4'd0;
            partial_value_reg <= '0;
        end
        else if (cfg_we && cfg_index == pvc_pkg::CFG_DIRECTION)
        begin
            // direction change drops any decode in progress
            bytes_left_reg    <= 4'd0;
            header_seen_reg   <= 8'd0;
            byte_position_reg <= 4'd0;
            partial_value_reg <= '0;
        end
        else if (accept && direction_reg == pvc_pkg::DIR_DECODE)
        begin
            bytes_left_reg    <= bytes_left_next;
            header_seen_reg   <= header_seen_next;
            byte_position_reg <= byte_position_next;
            partial_value_reg <= partial_value_next;
        end
    end

    assign push     = accept & ((direction_reg == pvc_pkg::DIR_ENCODE) | dec_done);
    assign push_job = (direction_reg == pvc_pkg::DIR_DECODE) ? dec_job : enc_job;

    // a pending payload count only exists behind a multi-byte header
    a_header_held: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != 4'd0) |-> (header_seen_reg > pvc_pkg::HDR_ONE_MAX))
        else $error("payload pending without a multi-byte header");

endmodule

@@ src/pvc_queue.sv @@
// short job queue between front and back
`timescale 1ns / 1ps

module pvc_queue #(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pvc_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output pvc_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pvc_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push & ~full;
    assign do_pop   = pop & ~empty;
    assign head_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("front pushed into a full queue");

endmodule

@@ src/pvc_back.sv @@
// back part: steps through the queued job one output beat at a time
`timescale 1ns / 1ps

module pvc_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  pvc_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [71:0]   out_data,
    output logic          out_last
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic [7:0] byte_sel;
    logic       beat;

    always_comb
    begin
        byte_sel = '0;
        for (int i = 0; i < pvc_pkg::BYTES_MAX; i++)
        begin
            if (idx_reg == 4'(i))
                byte_sel = head_job.bytes[i*8 +: 8];
        end
    end

    assign out_valid = ~empty;
    assign out_last  = head_job.is_decode | (idx_reg == head_job.count - 4'd1);
    assign out_data  = head_job.is_decode ? {head_job.value, 8'd0} : {64'd0, byte_sel};
    assign beat      = out_valid & out_ready;
    assign pop       = beat & out_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (beat)
            idx_next = out_last ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 4'd0;
        else
            idx_reg <= idx_next;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (idx_reg < head_job.count))
        else $error("byte index ran past the job length");

endmodule

@@ src/prefix_varint_codec.sv @@
// top level of the prefix varint codec
`timescale 1ns / 1ps
// output: a result beat is offered once its job, pushed by the input beat that completes it, heads the queue
// input: one input beat per cycle while the job queue is not full; an encode item then takes 1 to 9 output
//   beats (header plus payload), set by the back stage's byte sequencer
// decode takes one byte per cycle while the queue has room and yields one value beat after its last byte
// reset: queue emptied, decode state cleared, encode direction, unsigned mode

module prefix_varint_codec #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes: index 0 direction, index 1 signed mode
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic        cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // value_in [63:0], byte_in [71:64]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // byte_out [7:0], value_out [71:8]
    output logic        m_tlast
);

    logic          push;
    pvc_pkg::job_t push_job;
    logic          queue_full;
    logic          pop;
    logic          queue_empty;
    pvc_pkg::job_t head_job;

    // input side stalls only when the job queue is full
    assign s_tready = ~queue_full;

    // front: config registers, zigzag, header choice, decode byte gathering
    pvc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .push      (push),
        .push_job  (push_job)
    );

    // jobs wait here so a long encode burst does not stall input beats at once
    pvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head_job (head_job)
    );

    // back: emits one beat per cycle while a job waits and m_tready is high, a whole job pops on its last beat
    pvc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the prefix varint codec
`timescale 1ns / 1ps

module testbench;

    // cycles allowed with no beat, no write: far above the longest stall or gap
    localparam int STALL_LIMIT   = 4000;
    // cycles to let queued decode bytes drain before a register write
    localparam int SETTLE_CYCLES = 16;

    // one output beat as the block presents it
    typedef struct packed {
        logic [7:0]  byte_out;
        logic [63:0] value_out;
        logic        last;
    } codec_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;    // value_in [63:0], byte_in [71:64]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;    // byte_out [7:0], value_out [71:8]
    logic        m_tlast;

    // predictor copy of the registers and of the decode state
    logic        cur_dir    = pvc_pkg::DIR_ENCODE;
    logic        cur_signed = 1'b0;
    logic [3:0]  dec_left    = '0;
    logic [7:0]  dec_header  = '0;
    logic [3:0]  dec_pos     = '0;
    logic [63:0] dec_partial = '0;

    codec_beat_t pending_beats[$];
    int          errors      = 0;
    int          idle_cycles = 0;
    int          rx_hold     = 0;
    bit          steady_flow = 1'b0;

    prefix_varint_codec dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic [63:0] zigzag_fold(input logic [63:0] v);
        return (v << 1) ^ {64{v[63]}};
    endfunction

    function automatic logic [63:0] zigzag_unfold(input logic [63:0] v);
        return (v >> 1) ^ {64{v[0]}};
    endfunction

    // byte k of the encoding sits at seq[8k +: 8]; returns the byte count
    function automatic int varint_pack(input logic [63:0] u, output logic [71:0] seq);
        logic [63:0] d;
        logic [63:0] lim;
        int          hdr;
        int          n;
        seq = '0;
        if (u <= pvc_pkg::VAL_ONE_MAX)
        begin
            seq[7:0] = u[7:0];
            return 1;
        end
        if (u <= pvc_pkg::VAL_TWO_MAX)
        begin
            d         = u - pvc_pkg::VAL_ONE_MAX;
            seq[7:0]  = d[15:8] + pvc_pkg::HDR_TWO_BASE;
            seq[15:8] = d[7:0];
            return 2;
        end
        if (u <= pvc_pkg::VAL_THREE_MAX)
        begin
            d          = u - pvc_pkg::VAL_THREE_BASE;
            seq[7:0]   = pvc_pkg::HDR_THREE;
            seq[15:8]  = d[15:8];
            seq[23:16] = d[7:0];
            return 3;
        end
        hdr = 255;
        lim = 64'h00FF_FFFF_FFFF_FFFF;
        while (hdr > 250 && u <= lim)
        begin
            hdr = hdr - 1;
            lim = lim >> 8;
        end
        n        = hdr - 247;
        seq[7:0] = hdr[7:0];
        for (int i = 0; i < n; i++)
            seq[8*(i+1) +: 8] = u[8*i +: 8];
        return n + 1;
    endfunction

    task automatic push_decoded(input logic [63:0] r);
        codec_beat_t b;
        b.byte_out  = 8'd0;
        b.value_out = cur_signed ? zigzag_unfold(r) : r;
        b.last      = 1'b1;
        pending_beats.push_back(b);
    endtask

    task automatic clear_decode_state();
        dec_left    = '0;
        dec_header  = '0;
        dec_pos     = '0;
        dec_partial = '0;
    endtask

    task automatic predict_encode(input logic [63:0] v);
        logic [71:0] seq;
        logic [63:0] u;
        codec_beat_t b;
        int          n;
        u = cur_signed ? zigzag_fold(v) : v;
        n = varint_pack(u, seq);
        for (int k = 0; k < n; k++)
        begin
            b.byte_out  = seq[8*k +: 8];
            b.value_out = 64'd0;
            b.last      = (k == n - 1);
            pending_beats.push_back(b);
        end
    endtask

    task automatic predict_decode(input logic [7:0] b);
        logic [63:0] r;
        if (dec_left == 0)
        begin
            if (b <= pvc_pkg::HDR_ONE_MAX)
                push_decoded({56'd0, b});
            else
            begin
                dec_header  = b;
                dec_pos     = '0;
                dec_partial = '0;
                if (b <= pvc_pkg::HDR_TWO_MAX)
                    dec_left = 4'd1;
                else if (b == pvc_pkg::HDR_THREE)
                    dec_left = 4'd2;
                else
                    dec_left = 4'(b - pvc_pkg::HDR_WIDE_BASE);
            end
        end
        else
        begin
            // the three-byte form is big-endian, the wide forms little-endian
            if (dec_header == pvc_pkg::HDR_THREE)
                dec_partial = {dec_partial[55:0], b};
            else
                dec_partial = dec_partial | ({56'd0, b} << (8 * dec_pos[2:0]));
            dec_pos  = dec_pos + 4'd1;
            dec_left = dec_left - 4'd1;
            if (dec_left == 0)
            begin
                if (dec_header <= pvc_pkg::HDR_TWO_MAX)
                    r = pvc_pkg::VAL_ONE_MAX
                        + ({56'd0, 8'(dec_header - pvc_pkg::HDR_TWO_BASE)} << 8)
                        + dec_partial;
                else if (dec_header == pvc_pkg::HDR_THREE)
                    r = pvc_pkg::VAL_THREE_BASE + dec_partial;
                else
                    r = dec_partial;
                clear_decode_state();
                push_decoded(r);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // checking, prediction on accepted beats, watchdog
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_and_predict
        codec_beat_t want;
        logic        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // results first: an expectation pushed at this edge is not yet due
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                if (pending_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat byte_out=%0h value_out=%0h last=%0b",
                             $time, m_tdata[7:0], m_tdata[71:8], m_tlast);
                    errors++;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (m_tdata[7:0] !== want.byte_out)
                    begin
                        $display("%0t: byte_out expected %0h actual %0h",
                                 $time, want.byte_out, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[71:8] !== want.value_out)
                    begin
                        $display("%0t: value_out expected %0h actual %0h",
                                 $time, want.value_out, m_tdata[71:8]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                if (cur_dir == pvc_pkg::DIR_ENCODE)
                    predict_encode(s_tdata[63:0]);
                else
                    predict_decode(s_tdata[71:64]);
            end
            if (cfg_we)
            begin
                moved = 1'b1;
                if (cfg_index == pvc_pkg::CFG_DIRECTION)
                begin
                    // any direction write drops a decode in progress
                    cur_dir = cfg_data;
                    clear_decode_state();
                end
                else
                    cur_signed = cfg_data;
            end
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("prefix_varint_codec test failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    // offer one beat; returns at the edge where it is taken
    task automatic send_beat(input logic [63:0] v, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, v};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // value_in matters in encode direction only, byte_in in decode only
    task automatic send_value(input logic [63:0] v);
        send_beat(v, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat({$urandom, $urandom}, b);
    endtask

    // hold the sender until every result is out and the block is quiet
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic index, input logic data);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // value spread over all encoded lengths, edge patterns now and then
    function automatic logic [63:0] rand_value();
        logic [63:0] raw;
        logic [63:0] mask;
        int          k;
        k    = $urandom_range(0, 64);
        raw  = {$urandom, $urandom};
        mask = (k == 64) ? '1 : ((64'd1 << k) - 64'd1);
        if ($urandom_range(0, 9) == 0)
            return mask;
        return raw & mask;
    endfunction

    // payload length that a header byte announces
    function automatic int payload_len(input logic [7:0] hdr);
        if (hdr <= pvc_pkg::HDR_ONE_MAX)
            return 0;
        if (hdr <= pvc_pkg::HDR_TWO_MAX)
            return 1;
        if (hdr == pvc_pkg::HDR_THREE)
            return 2;
        return hdr - pvc_pkg::HDR_WIDE_BASE;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_encode_edges();
        logic [63:0] edge_vals[10];
        edge_vals = '{64'd0, 64'd240, 64'd241, 64'd2287, 64'd2288, 64'd67823,
                      64'd67824, 64'h00FF_FFFF, 64'h0100_0000, '1};
        set_reg(pvc_pkg::CFG_DIRECTION, pvc_pkg::DIR_ENCODE);
        set_reg(pvc_pkg::CFG_SIGNED_MODE, 1'b0);
        foreach (edge_vals[i])
            send_value(edge_vals[i]);
    endtask

    task automatic test_signed_encode();
        set_reg(pvc_pkg::CFG_SIGNED_MODE, 1'b1);
        send_value(64'h8000_0000_0000_0000);
        send_value('1);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_decode_headers();
        set_reg(pvc_pkg::CFG_DIRECTION, pvc_pkg::DIR_DECODE);
        set_reg(pvc_pkg::CFG_SIGNED_MODE, 1'b0);
        send_byte(8'd0);
        send_byte(8'd240);
        // two-byte form, top header
        send_byte(8'd248);
        send_byte(8'hFF);
        // three-byte form
        send_byte(pvc_pkg::HDR_THREE);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // widest form, all payload bits set
        send_byte(8'd255);
        repeat (8) send_byte(8'hFF);
    endtask

    // direction write with a header and part of its payload taken
    task automatic test_decode_abandon();
        send_byte(8'd252);
        send_byte(8'h11);
        set_reg(pvc_pkg::CFG_DIRECTION, pvc_pkg::DIR_DECODE);
        send_byte(8'h05);
    endtask

    // signed mode that holds at the last byte decides the result
    task automatic test_signed_switch_mid_decode();
        send_byte(8'd241);
        set_reg(pvc_pkg::CFG_SIGNED_MODE, 1'b1);
        send_byte(8'h03);
    endtask

    task automatic test_random_encode(input int count, input logic signed_on);
        logic [63:0] v;
        set_reg(pvc_pkg::CFG_DIRECTION, pvc_pkg::DIR_ENCODE);
        set_reg(pvc_pkg::CFG_SIGNED_MODE, signed_on);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            v = rand_value();
            if (signed_on && $urandom_range(0, 1))
                v = ~v;
            send_value(v);
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_random_decode(input int count, input logic signed_on);
        logic [71:0] seq;
        int          n;
        int          cut;
        int          sent;
        int          frames;
        int          pick;
        set_reg(pvc_pkg::CFG_DIRECTION, pvc_pkg::DIR_DECODE);
        set_reg(pvc_pkg::CFG_SIGNED_MODE, signed_on);
        sent   = 0;
        frames = 0;
        while (sent < count)
        begin
            if (frames % 12 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            frames++;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                n = varint_pack(rand_value(), seq);
            else
            begin
                // any header with arbitrary payload, non-minimal forms among them
                seq[7:0] = 8'($urandom_range(0, 255));
                n = payload_len(seq[7:0]) + 1;
                for (int k = 1; k < n; k++)
                    seq[8*k +: 8] = 8'($urandom);
            end
            cut = n;
            if (pick >= 90 && n > 1)
                cut = $urandom_range(1, n - 1);
            for (int k = 0; k < cut; k++)
                send_byte(seq[8*k +: 8]);
            sent += cut;
            if (cut < n)
            begin
                if (pick < 95)
                    // broken frame: a direction write drops the partial value
                    set_reg(pvc_pkg::CFG_DIRECTION, pvc_pkg::DIR_DECODE);
                else
                begin
                    set_reg(pvc_pkg::CFG_SIGNED_MODE, !signed_on);
                    for (int k = cut; k < n; k++)
                        send_byte(seq[8*k +: 8]);
                    sent += n - cut;
                    set_reg(pvc_pkg::CFG_SIGNED_MODE, signed_on);
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = pvc_pkg::CFG_DIRECTION;
        cfg_data  = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_encode_edges();
        test_signed_encode();
        test_decode_headers();
        test_decode_abandon();
        test_signed_switch_mid_decode();
        test_random_encode(80, 1'b0);
        test_random_encode(80, 1'b1);
        test_random_decode(80, 1'b0);
        test_random_decode(80, 1'b1);
        test_random_encode(20, 1'b0);

        settle();
        if (errors == 0 && pending_beats.size() == 0)
            $display("prefix_varint_codec test passed");
        else
            $display("prefix_varint_codec test failed");
        $finish;
    end

endmodule
